>>> design/hsd_pkg.sv
// hsd_pkg: shared types, widths and elaboration-time helpers for the
// Hamming single-error-correcting decoder. No dependencies.
`default_nettype none

package hsd_pkg;

  localparam int unsigned DATA_W = 57;  // packed data field width
  localparam int unsigned POS_W  = 7;   // syndrome / position width
  localparam int unsigned LEN_W  = 6;   // data length register width
  localparam int unsigned APB_AW = 3;   // byte address width of the register port
  localparam int unsigned APB_DW = 32;

  // Word address of the data length register (byte address 0).
  localparam logic ADDR_DATA_LEN = 1'b0;

  localparam logic [LEN_W-1:0] DATA_LEN_RST = LEN_W'(4);

  // Effective code geometry handed from the register block to the datapath.
  typedef struct packed {
    logic [POS_W-1:0] code_len;  // codeword length n, in positions
    logic [LEN_W-1:0] data_len;  // clamped data length d
  } cfg_t;

  // Least r with 2^r >= d + r + 1 (r <= 7 for d <= 63).
  function automatic logic [2:0] parity_count(input logic [LEN_W-1:0] d);
    logic [2:0] r;
    logic       found;
    r     = 3'd7;
    found = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!found && ((9'd1 << k) >= (9'(d) + 9'(k) + 9'd1))) begin
        r     = 3'(k);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  // Largest data length whose codeword fits in code_bits positions.
  function automatic int unsigned max_data_len(input int unsigned code_bits);
    int unsigned best;
    best = 1;
    for (int unsigned d = 1; d < 64; d++) begin
      if (d + int'(parity_count(LEN_W'(d))) <= code_bits) begin
        best = d;
      end
    end
    return best;
  endfunction

  // One-based codeword position of packed data bit j (j-th non-power-of-two).
  function automatic int unsigned data_pos(input int unsigned j);
    int unsigned cnt;
    int unsigned pos;
    cnt = 0;
    pos = 0;
    for (int unsigned q = 1; q < 128; q++) begin
      if ((q & (q - 1)) != 0) begin
        if (cnt == j && pos == 0) begin
          pos = q;
        end
        cnt++;
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

>>> design/hsd_cfg.sv
// hsd_cfg: APB register block holding data_len and the derived code geometry.
// Depends on hsd_pkg.
`default_nettype none

module hsd_cfg #(
  parameter int unsigned MaxData = 57
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [hsd_pkg::APB_AW-1:0] paddr,
  input  wire logic [hsd_pkg::APB_DW-1:0] pwdata,
  output logic      [hsd_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output hsd_pkg::cfg_t                   cfg
);

  // geometry of the reset length, clamped like any written value
  localparam logic [hsd_pkg::LEN_W-1:0] DataRst =
    (hsd_pkg::DATA_LEN_RST > hsd_pkg::LEN_W'(MaxData)) ? hsd_pkg::LEN_W'(MaxData)
                                                       : hsd_pkg::DATA_LEN_RST;
  localparam logic [hsd_pkg::POS_W-1:0] CodeRst =
    hsd_pkg::POS_W'(DataRst) + hsd_pkg::POS_W'(hsd_pkg::parity_count(DataRst));

  logic [hsd_pkg::LEN_W-1:0] data_len_r, data_len_nxt;
  hsd_pkg::cfg_t             geom_r, geom_nxt;
  logic                      hit;
  logic [hsd_pkg::LEN_W-1:0] d_raw;
  logic [hsd_pkg::LEN_W-1:0] d_eff;

  assign hit    = (paddr[hsd_pkg::APB_AW-1] == hsd_pkg::ADDR_DATA_LEN);
  assign pready = 1'b1;

  always_comb begin
    data_len_nxt = data_len_r;
    if (psel && penable && pwrite && hit) begin
      data_len_nxt = pwdata[hsd_pkg::LEN_W-1:0];
    end
    // zero means one; clamp so the codeword fits the port
    d_raw = (data_len_nxt == '0) ? hsd_pkg::LEN_W'(1) : data_len_nxt;
    d_eff = (d_raw > hsd_pkg::LEN_W'(MaxData)) ? hsd_pkg::LEN_W'(MaxData) : d_raw;
    geom_nxt.data_len = d_eff;
    geom_nxt.code_len = hsd_pkg::POS_W'(d_eff) +
                        hsd_pkg::POS_W'(hsd_pkg::parity_count(d_eff));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_len_r      <= hsd_pkg::DATA_LEN_RST;
      geom_r.data_len <= DataRst;
      geom_r.code_len <= CodeRst;
    end else begin
      data_len_r <= data_len_nxt;
      geom_r     <= geom_nxt;
    end
  end

  assign prdata = hit ? hsd_pkg::APB_DW'(data_len_r) : '0;
  assign cfg    = geom_r;

endmodule

`default_nettype wire

>>> design/hsd_correct.sv
// hsd_correct: syndrome, single-bit correction and data packing for one
// codeword (combinational). Depends on hsd_pkg.
`default_nettype none

module hsd_correct #(
  parameter int unsigned CodeBits = 64
) (
  input  wire logic [CodeBits-1:0]          codeword,
  input  hsd_pkg::cfg_t                     cfg,
  output logic      [hsd_pkg::DATA_W-1:0]   data_out,
  output logic                              error_found,
  output logic      [hsd_pkg::POS_W-1:0]    error_position
);

  logic [CodeBits-1:0]        len_mask;
  logic [CodeBits-1:0]        cw_m;
  logic [CodeBits-1:0]        cw_fix;
  logic [hsd_pkg::POS_W-1:0]  syn;

  // positions whose one-based index has bit i set
  function automatic logic [CodeBits-1:0] group_mask(input int unsigned i);
    logic [CodeBits-1:0] m;
    m = '0;
    for (int unsigned k = 0; k < CodeBits; k++) begin
      m[k] = (((k + 1) >> i) & 1) != 0;
    end
    return m;
  endfunction

  always_comb begin
    for (int k = 0; k < CodeBits; k++) begin
      len_mask[k] = (hsd_pkg::POS_W'(k) < cfg.code_len);
    end
    cw_m = codeword & len_mask;
    for (int i = 0; i < hsd_pkg::POS_W; i++) begin
      syn[i] = ^(cw_m & group_mask(i));
    end
    // flip only inside the codeword
    for (int k = 0; k < CodeBits; k++) begin
      cw_fix[k] = cw_m[k] ^ (len_mask[k] && (syn == hsd_pkg::POS_W'(k + 1)));
    end
  end

  for (genvar j = 0; j < hsd_pkg::DATA_W; j++) begin : g_pack
    localparam int unsigned Pos = hsd_pkg::data_pos(j);
    if (Pos <= CodeBits) begin : g_bit
      assign data_out[j] = cw_fix[Pos-1];
    end else begin : g_zero
      assign data_out[j] = 1'b0;
    end
  end

  assign error_found    = (syn != '0);
  assign error_position = syn;

endmodule

`default_nettype wire

>>> design/hamming_sec_decoder.sv
// hamming_sec_decoder: top level, input and result registers around the
// correction datapath, plus the APB register block. Depends on hsd_pkg,
// hsd_cfg and hsd_correct.
`default_nettype none

// Hamming single-error-correcting decoder. Each beat on the in_ channel
// carries one codeword, position 1 in bit 0; its length n is data_len plus
// the least r with 2^r >= data_len + r + 1, and bits at or above n are
// ignored. The block forms the even-parity syndrome over the codeword,
// flips the bit it names when that position lies inside the codeword, drops
// the parity positions and returns the packed data bits, zero above
// data_len, together with the syndrome (error_position) and a nonzero flag
// (error_found). A syndrome at a parity position or past the codeword end
// is reported but changes no data bit. data_len of zero acts as one, and a
// data_len too large for CODE_BITS is clamped (57 for 64 bits).
// Throughput is one codeword per clock while out_ready holds; a beat goes
// through the input register, then the result register, with the parity
// trees, corrector and packer between them. The input side keeps taking
// beats while a result waits, until both registers are full. data_len is
// written through the APB port at byte address 0; the user writes it only
// while the block holds no unfinished beat (unenforced); reset value is 4.

module hamming_sec_decoder #(
  parameter int unsigned CODE_BITS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // codeword beats
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [CODE_BITS-1:0]       in_codeword,
  // result beats
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [hsd_pkg::DATA_W-1:0] out_data_out,
  output logic                            out_error_found,
  output logic      [hsd_pkg::POS_W-1:0]  out_error_position,
  // register port
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [hsd_pkg::APB_AW-1:0] cfg_paddr,
  input  wire logic [hsd_pkg::APB_DW-1:0] cfg_pwdata,
  output logic      [hsd_pkg::APB_DW-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int unsigned MaxData = hsd_pkg::max_data_len(CODE_BITS);

  hsd_pkg::cfg_t cfg;

  // input stage
  logic                 s1_valid_r, s1_valid_nxt;
  logic [CODE_BITS-1:0] s1_cw_r;

  // result stage
  logic                       out_valid_r, out_valid_nxt;
  logic [hsd_pkg::DATA_W-1:0] data_r;
  logic                       err_r;
  logic [hsd_pkg::POS_W-1:0]  pos_r;

  logic                       fix_data;
  logic [hsd_pkg::DATA_W-1:0] fix_data_out;
  logic                       fix_err;
  logic [hsd_pkg::POS_W-1:0]  fix_pos;
  logic                       adv;   // result stage may load

  hsd_cfg #(
    .MaxData (MaxData)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  hsd_correct #(
    .CodeBits (CODE_BITS)
  ) u_correct (
    .codeword       (s1_cw_r),
    .cfg            (cfg),
    .data_out       (fix_data_out),
    .error_found    (fix_err),
    .error_position (fix_pos)
  );

  // the result register frees up when empty or being drained
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;
  assign fix_data = adv && s1_valid_r;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (in_ready && in_valid) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cw_r <= in_codeword;
    end
    if (fix_data) begin
      data_r <= fix_data_out;
      err_r  <= fix_err;
      pos_r  <= fix_pos;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data_out       = data_r;
  assign out_error_found    = err_r;
  assign out_error_position = pos_r;

  // ---- assertions ----

  // flag and syndrome agree on every result beat
  a_flag_matches_syn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error_found == (out_error_position != '0)))
    else $error("error_found disagrees with error_position");

  // nothing packed above the configured data length
  a_data_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data_out >> cfg.data_len) == '0))
    else $error("data_out has bits above data length");

  // input side only backs up when the result is stalled
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && s1_valid_r))
    else $error("in_ready low without output stall");

  // a loaded input stage reaches the result register on the next free edge
  a_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv) |=> out_valid)
    else $error("input stage did not advance");

endmodule

`default_nettype wire
